FILE: sv/amla_pkg.sv
// Shared types and constants for the logical / saturate / pack / SAD execute unit.
// No dependencies; imported by every module of the block.
package amla_pkg;

    localparam int DATA_W  = 32;
    localparam int HALF_W  = 16;
    localparam int KIND_W  = 5;
    localparam int SHIFT_W = 5;
    localparam int SAT_W   = 5;

    localparam logic [DATA_W-1:0] LO_HALF = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] HI_HALF = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] LO_BYTE = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] HI_BYTE = 32'hFF00_0000;
    localparam logic [SHIFT_W-1:0] FULL_ASR = 5'd31;

    typedef enum logic [KIND_W-1:0] {
        OP_AND    = 5'd0,
        OP_CLZ    = 5'd1,
        OP_EOR    = 5'd2,
        OP_CMP    = 5'd3,
        OP_CMN    = 5'd4,
        OP_BIC    = 5'd5,
        OP_ORR    = 5'd6,
        OP_TEQ    = 5'd7,
        OP_TST    = 5'd8,
        OP_REV    = 5'd9,
        OP_REV16  = 5'd10,
        OP_REVSH  = 5'd11,
        OP_PKHBT  = 5'd12,
        OP_PKHTB  = 5'd13,
        OP_SSAT   = 5'd14,
        OP_SSAT16 = 5'd15,
        OP_USAT   = 5'd16,
        OP_USAT16 = 5'd17,
        OP_USAD8  = 5'd18,
        OP_USADA8 = 5'd19
    } t_op;

    typedef struct packed {
        t_op                kind;
        logic [DATA_W-1:0]  first_operand;
        logic [DATA_W-1:0]  second_operand;
        logic [DATA_W-1:0]  third_operand;
        logic               shifter_carry;
        logic [SHIFT_W-1:0] shift_amount;
        logic               shift_is_asr;
        logic [SAT_W-1:0]   sat_field;
        logic               set_flags;
        logic               dest_is_pc;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              result_write;
        logic              flag_n;
        logic              flag_z;
        logic              flag_c;
        logic              flag_v;
        logic              nzc_write;
        logic              v_write;
        logic              restore_status;
        logic              q_set;
    } t_result;

endpackage

FILE: sv/amla_sat.sv
// Saturating clamp of a two's complement value to a selectable bit width.
// Depends on amla_pkg for the default width.
module amla_sat #(
    parameter int WIDTH = amla_pkg::DATA_W
) (
    input  logic [WIDTH-1:0]         i_value,
    input  logic [$clog2(WIDTH)-1:0] i_count,
    input  logic                     i_signed,
    output logic [WIDTH-1:0]         o_value,
    output logic                     o_sat
);
    import amla_pkg::*;

    logic [WIDTH-1:0] up_mask;
    logic [WIDTH-1:0] upper;
    logic             neg;

    // Signed: keep count+1 bits, so bits from count upwards must all match the sign.
    // Unsigned: keep count bits, so bits from count upwards must all be zero.
    assign up_mask = {WIDTH{1'b1}} << i_count;
    assign upper   = i_value & up_mask;
    assign neg     = i_value[WIDTH-1];

    always_comb begin
        o_value = i_value;
        o_sat   = 1'b0;
        if (i_signed) begin
            if (!neg && (upper != '0)) begin
                o_value = ~up_mask;
                o_sat   = 1'b1;
            end else if (neg && (upper != up_mask)) begin
                o_value = up_mask;
                o_sat   = 1'b1;
            end
        end else begin
            if (neg) begin
                o_value = '0;
                o_sat   = 1'b1;
            end else if (upper != '0) begin
                o_value = ~up_mask;
                o_sat   = 1'b1;
            end
        end
    end

endmodule

FILE: sv/amla_core.sv
// Combinational datapath of the execute unit: one registered item in, one result out.
// Depends on amla_pkg and amla_sat.
module amla_core (
    input  amla_pkg::t_item   i_item,
    output amla_pkg::t_result o_res
);
    import amla_pkg::*;

    localparam int CLZ_W = $clog2(DATA_W) + 1;
    localparam int SAD_W = 10;

    function automatic logic [CLZ_W-1:0] clz32(input logic [DATA_W-1:0] x);
        logic [CLZ_W-1:0]  n;
        logic [DATA_W-1:0] v;
        n = '0;
        v = x;
        if (v[31:16] == '0) begin n = n + 6'd16; v = v << 16; end
        if (v[31:24] == '0) begin n = n + 6'd8;  v = v << 8;  end
        if (v[31:28] == '0) begin n = n + 6'd4;  v = v << 4;  end
        if (v[31:30] == '0) begin n = n + 6'd2;  v = v << 2;  end
        if (v[31] == 1'b0)  begin n = n + 6'd1;  end
        if (x == '0) n = 6'd32;
        return n;
    endfunction

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [DATA_W-1:0]   rn, op2, rs;
    logic [DATA_W-1:0]   sat_in, sat32_out, pkh_asr;
    logic                sat32_q, satlo_q, sathi_q;
    logic [HALF_W-1:0]   satlo_out, sathi_out;
    logic [SHIFT_W-1:0]  asr_count;
    logic [DATA_W-1:0]   addend;
    logic [DATA_W:0]     sum;
    logic [SAD_W-1:0]    sad;
    logic [DATA_W-1:0]   tst;
    logic                is_logic;

    assign rn  = i_item.first_operand;
    assign op2 = i_item.second_operand;
    assign rs  = i_item.third_operand;

    // A zero shift in the ASR forms means a shift of 32: all sign bits.
    assign asr_count = (i_item.shift_amount == '0) ? FULL_ASR : i_item.shift_amount;
    assign sat_in    = i_item.shift_is_asr ? DATA_W'($signed(op2) >>> asr_count)
                                           : (op2 << i_item.shift_amount);
    assign pkh_asr   = DATA_W'($signed(op2) >>> asr_count);

    amla_sat #(.WIDTH(DATA_W)) u_sat32 (
        .i_value  (sat_in),
        .i_count  (i_item.sat_field),
        .i_signed (i_item.kind == OP_SSAT),
        .o_value  (sat32_out),
        .o_sat    (sat32_q)
    );

    amla_sat #(.WIDTH(HALF_W)) u_sat_lo (
        .i_value  (op2[15:0]),
        .i_count  (i_item.sat_field[3:0]),
        .i_signed (i_item.kind == OP_SSAT16),
        .o_value  (satlo_out),
        .o_sat    (satlo_q)
    );

    amla_sat #(.WIDTH(HALF_W)) u_sat_hi (
        .i_value  (op2[31:16]),
        .i_count  (i_item.sat_field[3:0]),
        .i_signed (i_item.kind == OP_SSAT16),
        .o_value  (sathi_out),
        .o_sat    (sathi_q)
    );

    // One adder serves CMP (rn + ~op2 + 1) and CMN (rn + op2).
    assign addend = (i_item.kind == OP_CMP) ? ~op2 : op2;
    assign sum    = {1'b0, rn} + {1'b0, addend} + {{DATA_W{1'b0}}, i_item.kind == OP_CMP};

    assign sad = SAD_W'(absdiff8(op2[7:0],   rs[7:0]))   + SAD_W'(absdiff8(op2[15:8],  rs[15:8]))
               + SAD_W'(absdiff8(op2[23:16], rs[23:16])) + SAD_W'(absdiff8(op2[31:24], rs[31:24]));

    assign tst = (i_item.kind == OP_TEQ) ? (rn ^ op2) : (rn & op2);

    always_comb begin
        o_res    = '0;
        is_logic = 1'b0;
        case (i_item.kind)
            OP_AND: begin o_res.result = rn & op2;  o_res.result_write = 1'b1; is_logic = 1'b1; end
            OP_EOR: begin o_res.result = rn ^ op2;  o_res.result_write = 1'b1; is_logic = 1'b1; end
            OP_BIC: begin o_res.result = rn & ~op2; o_res.result_write = 1'b1; is_logic = 1'b1; end
            OP_ORR: begin o_res.result = rn | op2;  o_res.result_write = 1'b1; is_logic = 1'b1; end
            OP_CLZ: begin
                o_res.result       = DATA_W'(clz32(op2));
                o_res.result_write = 1'b1;
            end
            OP_CMP, OP_CMN: begin
                o_res.flag_n    = sum[31];
                o_res.flag_z    = (sum[DATA_W-1:0] == '0);
                o_res.flag_c    = sum[DATA_W];
                o_res.flag_v    = (rn[31] == addend[31]) && (sum[31] != rn[31]);
                o_res.nzc_write = 1'b1;
                o_res.v_write   = 1'b1;
            end
            OP_TEQ, OP_TST: begin
                o_res.flag_n    = tst[31];
                o_res.flag_z    = (tst == '0);
                o_res.flag_c    = i_item.shifter_carry;
                o_res.nzc_write = 1'b1;
            end
            OP_REV: begin
                o_res.result       = ((op2 & LO_BYTE) << 24) | ((op2 << 8) & 32'h00FF_0000)
                                   | ((op2 >> 8) & 32'h0000_FF00) | ((op2 & HI_BYTE) >> 24);
                o_res.result_write = 1'b1;
            end
            OP_REV16: begin
                o_res.result       = {op2[23:16], op2[31:24], op2[7:0], op2[15:8]};
                o_res.result_write = 1'b1;
            end
            OP_REVSH: begin
                o_res.result       = {{HALF_W{op2[7]}}, op2[7:0], op2[15:8]};
                o_res.result_write = 1'b1;
            end
            OP_PKHBT: begin
                o_res.result       = (rn & LO_HALF) | ((op2 << i_item.shift_amount) & HI_HALF);
                o_res.result_write = 1'b1;
            end
            OP_PKHTB: begin
                o_res.result       = (pkh_asr & LO_HALF) | (rn & HI_HALF);
                o_res.result_write = 1'b1;
            end
            OP_SSAT, OP_USAT: begin
                o_res.result       = sat32_out;
                o_res.result_write = 1'b1;
                o_res.q_set        = sat32_q;
            end
            OP_SSAT16, OP_USAT16: begin
                o_res.result       = {sathi_out, satlo_out};
                o_res.result_write = 1'b1;
                o_res.q_set        = satlo_q | sathi_q;
            end
            OP_USAD8: begin
                o_res.result       = DATA_W'(sad);
                o_res.result_write = 1'b1;
            end
            OP_USADA8: begin
                o_res.result       = rn + DATA_W'(sad);
                o_res.result_write = 1'b1;
            end
            default: begin
                o_res = '0;
            end
        endcase

        if (is_logic && i_item.set_flags) begin
            if (i_item.dest_is_pc) begin
                o_res.restore_status = 1'b1;
            end else begin
                o_res.flag_n    = o_res.result[31];
                o_res.flag_z    = (o_res.result == '0);
                o_res.flag_c    = i_item.shifter_carry;
                o_res.nzc_write = 1'b1;
            end
        end
    end

endmodule

FILE: sv/arm_logic_media_alu_top.sv
// Top level of the logical / saturate / pack / SAD execute unit.
// Depends on amla_pkg and amla_core (which uses amla_sat).
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------------
//   in      | in        | i_in_valid / o_in_stall    | i_kind .. i_dest_is_pc (one item)
//   out     | out       | o_out_valid / i_out_stall  | o_result .. o_q_set (one result)
//
// An accepted item is loaded into the input register, then, once the result register is
// free, into the result register after a single pass through the datapath. Throughput is
// one item per cycle while the output does not stall, set by the two-register pipeline.
// Reset (i_rst_n low, synchronous) empties both stages; payload registers are not cleared.
// A stall on the output holds the result register; the input register then holds too, and
// the input side stalls only once both stages are full.
module arm_logic_media_alu_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [amla_pkg::KIND_W-1:0]   i_kind,
    input  logic [amla_pkg::DATA_W-1:0]   i_first_operand,
    input  logic [amla_pkg::DATA_W-1:0]   i_second_operand,
    input  logic [amla_pkg::DATA_W-1:0]   i_third_operand,
    input  logic                          i_shifter_carry,
    input  logic [amla_pkg::SHIFT_W-1:0]  i_shift_amount,
    input  logic                          i_shift_is_asr,
    input  logic [amla_pkg::SAT_W-1:0]    i_sat_field,
    input  logic                          i_set_flags,
    input  logic                          i_dest_is_pc,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [amla_pkg::DATA_W-1:0]   o_result,
    output logic                          o_result_write,
    output logic                          o_flag_n,
    output logic                          o_flag_z,
    output logic                          o_flag_c,
    output logic                          o_flag_v,
    output logic                          o_nzc_write,
    output logic                          o_v_write,
    output logic                          o_restore_status,
    output logic                          o_q_set
);
    import amla_pkg::*;

    // Pipeline occupancy
    logic    r_in_vld,  n_in_vld;
    logic    r_out_vld, n_out_vld;
    // Payload
    t_item   r_item;
    t_result r_res;
    t_result core_res;
    t_item   in_item;

    logic out_free;
    logic in_free;
    logic in_acc;
    logic advance;

    // The result register frees up when empty or when its item leaves this cycle;
    // the input register frees up when empty or when it can advance.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign in_free    = !r_in_vld || out_free;
    assign o_in_stall = !in_free;
    assign in_acc     = i_in_valid && in_free;
    assign advance    = r_in_vld && out_free;

    // Gather the input ports into one item; codes past the last operation fall to the
    // datapath's no-operation arm.
    always_comb begin
        in_item.kind           = t_op'(i_kind);
        in_item.first_operand  = i_first_operand;
        in_item.second_operand = i_second_operand;
        in_item.third_operand  = i_third_operand;
        in_item.shifter_carry  = i_shifter_carry;
        in_item.shift_amount   = i_shift_amount;
        in_item.shift_is_asr   = i_shift_is_asr;
        in_item.sat_field      = i_sat_field;
        in_item.set_flags      = i_set_flags;
        in_item.dest_is_pc     = i_dest_is_pc;
    end

    amla_core u_core (
        .i_item (r_item),
        .o_res  (core_res)
    );

    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        // Drop the input stage when it moves on, refill it on acceptance.
        if (advance) begin
            n_in_vld = 1'b0;
        end
        if (in_acc) begin
            n_in_vld = 1'b1;
        end
        // Advance into the result register, or empty it once taken.
        if (advance) begin
            n_out_vld = 1'b1;
        end else if (out_free) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= in_item;
        end
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_result         = r_res.result;
    assign o_result_write   = r_res.result_write;
    assign o_flag_n         = r_res.flag_n;
    assign o_flag_z         = r_res.flag_z;
    assign o_flag_c         = r_res.flag_c;
    assign o_flag_v         = r_res.flag_v;
    assign o_nzc_write      = r_res.nzc_write;
    assign o_v_write        = r_res.v_write;
    assign o_restore_status = r_res.restore_status;
    assign o_q_set          = r_res.q_set;

    // The input side only stalls when the input register holds an item.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld)
        else $error("input stalled with an empty input register");

    // An item in the input register reaches the output on the next edge when free.
    a_advance_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_free) |=> o_out_valid)
        else $error("item failed to reach the result register");

    // A status restore always writes the result and never comes with a flag update.
    a_restore_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_restore_status) |-> (!o_nzc_write && !o_v_write && o_result_write))
        else $error("status restore together with flag update");

    // Saturation only comes from an op that writes its destination, and flags are zero
    // when not written.
    a_clean_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((!o_q_set || o_result_write)
                         && (o_nzc_write || !(o_flag_n || o_flag_z || o_flag_c))
                         && (o_v_write || !o_flag_v)))
        else $error("flag value or Q set without its enable");

endmodule

FILE: tb/arm_logic_media_alu_top_tb.sv
// Self-checking bench for arm_logic_media_alu_top: a directed table, then random items.
// Results are checked against a local model of the execute unit or typed-in values; needs amla_pkg and the RTL.
module arm_logic_media_alu_top_tb;
    import amla_pkg::*;

    localparam int              CLK_HALF     = 10;
    localparam int              RESET_CYCLES = 12;
    localparam int              RANDOM_ITEMS = 1000;
    localparam int              IDLE_PCT     = 16;
    localparam int              HOLD_AT      = 300;    // receiver hold-off starts here
    localparam int              HOLD_CYCLES  = 80;
    localparam int              QUIET_FROM   = 500;    // no idling on either side in here
    localparam int              QUIET_TO     = 700;
    localparam int              DRAIN_AT     = 850;    // sender waits for every result here
    localparam int              TAIL_CYCLES  = 4;
    localparam int              CYCLE_LIMIT  = 100000;
    localparam logic [KIND_W-1:0] KIND_LAST  = 5'd31;  // highest code, no operation

    // One input item, fields at the widths of the ports.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  rn;
        logic [DATA_W-1:0]  op2;
        logic [DATA_W-1:0]  rs;
        logic               cin;
        logic [SHIFT_W-1:0] shift;
        logic               asr;
        logic [SAT_W-1:0]   sat;
        logic               s_bit;
        logic               pc_dest;
    } stim_t;

    // A directed row: the item, and a typed-in result where it is obvious.
    typedef struct packed {
        stim_t   item;
        logic    typed;
        t_result want;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    // Columns: kind, rn, op2, rs, cin, shift, asr, sat, s, pc
    dir_row_t directed_rows [DIR_ROWS] = '{
        // count leading zeros of zero, of the top bit, of the bottom bit
        '{'{OP_CLZ, 32'h0, 32'h0, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{result: 32'd32, result_write: 1'b1, default: 1'b0}},
        '{'{OP_CLZ, 32'h0, 32'h8000_0000, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{result: 32'd0, result_write: 1'b1, default: 1'b0}},
        '{'{OP_CLZ, 32'h0, 32'h1, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b0, '0},
        // logical: S with PC destination restores instead of flags, then S alone and PC alone
        '{'{OP_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 5'd0, 1'b0, 5'd0, 1'b1, 1'b1},
          1'b1, '{result: 32'hFFFF_FFFF, result_write: 1'b1, restore_status: 1'b1,
          default: 1'b0}},
        '{'{OP_EOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 5'd0, 1'b0, 5'd0, 1'b1, 1'b0},
          1'b0, '0},
        '{'{OP_BIC, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_ORR, 32'h0, 32'h0, 32'h0, 1'b1, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1}, 1'b0, '0},
        // compares: borrow, signed overflow, carry out with zero
        '{'{OP_CMP, 32'h0, 32'h1, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_CMP, 32'h8000_0000, 32'h1, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_CMN, 32'hFFFF_FFFF, 32'h1, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{flag_z: 1'b1, flag_c: 1'b1, nzc_write: 1'b1, v_write: 1'b1, default: 1'b0}},
        '{'{OP_CMN, 32'h7FFF_FFFF, 32'h1, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_TEQ, 32'h1234_5678, 32'h1234_5678, 32'h0, 1'b1, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0},
          1'b0, '0},
        '{'{OP_TST, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0},
          1'b0, '0},
        // byte reversals
        '{'{OP_REV, 32'h0, 32'h1122_3344, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{result: 32'h4433_2211, result_write: 1'b1, default: 1'b0}},
        '{'{OP_REV16, 32'h0, 32'h1122_3344, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_REVSH, 32'h0, 32'h0000_0080, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{result: 32'hFFFF_8000, result_write: 1'b1, default: 1'b0}},
        // packs: widest left shift, and a zero shift that means 32 to the right
        '{'{OP_PKHBT, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 1'b0, 5'd31, 1'b0, 5'd0, 1'b0, 1'b0},
          1'b0, '0},
        '{'{OP_PKHTB, 32'h1234_5678, 32'h8000_0000, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0},
          1'b1, '{result: 32'h1234_FFFF, result_write: 1'b1, default: 1'b0}},
        // saturation at the narrowest and widest settings
        '{'{OP_SSAT, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{result_write: 1'b1, q_set: 1'b1, default: 1'b0}},
        '{'{OP_SSAT, 32'h0, 32'h8000_0000, 32'h0, 1'b0, 5'd0, 1'b1, 5'd31, 1'b0, 1'b0},
          1'b0, '0},
        '{'{OP_USAT, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 5'd0, 1'b0, 5'd31, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_USAT, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{result_write: 1'b1, q_set: 1'b1, default: 1'b0}},
        '{'{OP_SSAT16, 32'h0, 32'h7FFF_8000, 32'h0, 1'b0, 5'd0, 1'b0, 5'd31, 1'b0, 1'b0},
          1'b0, '0},
        '{'{OP_USAT16, 32'h0, 32'h8000_7FFF, 32'h0, 1'b0, 5'd0, 1'b0, 5'd15, 1'b0, 1'b0},
          1'b0, '0},
        // sums of absolute differences, the accumulate wrapping round
        '{'{OP_USAD8, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0}, 1'b1,
          '{result: 32'h0000_03FC, result_write: 1'b1, default: 1'b0}},
        '{'{OP_USADA8, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0},
          1'b0, '0},
        // unused operation code: everything zero
        '{'{KIND_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd31, 1'b1, 5'd31,
            1'b1, 1'b1}, 1'b1, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [KIND_W-1:0]    i_kind;
    logic [DATA_W-1:0]    i_first_operand;
    logic [DATA_W-1:0]    i_second_operand;
    logic [DATA_W-1:0]    i_third_operand;
    logic                 i_shifter_carry;
    logic [SHIFT_W-1:0]   i_shift_amount;
    logic                 i_shift_is_asr;
    logic [SAT_W-1:0]     i_sat_field;
    logic                 i_set_flags;
    logic                 i_dest_is_pc;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [DATA_W-1:0]    o_result;
    logic                 o_result_write;
    logic                 o_flag_n;
    logic                 o_flag_z;
    logic                 o_flag_c;
    logic                 o_flag_v;
    logic                 o_nzc_write;
    logic                 o_v_write;
    logic                 o_restore_status;
    logic                 o_q_set;

    t_result              offered_result;     // expectation for the item on offer
    t_result              pending_results[$];
    int                   items_sent;
    int                   random_sent;
    int                   results_checked;
    int                   saturations_seen;
    int                   restores_seen;
    int                   mismatches;
    int                   cycle_count;

    arm_logic_media_alu_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_third_operand  (i_third_operand),
        .i_shifter_carry  (i_shifter_carry),
        .i_shift_amount   (i_shift_amount),
        .i_shift_is_asr   (i_shift_is_asr),
        .i_sat_field      (i_sat_field),
        .i_set_flags      (i_set_flags),
        .i_dest_is_pc     (i_dest_is_pc),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result         (o_result),
        .o_result_write   (o_result_write),
        .o_flag_n         (o_flag_n),
        .o_flag_z         (o_flag_z),
        .o_flag_c         (o_flag_c),
        .o_flag_v         (o_flag_v),
        .o_nzc_write      (o_nzc_write),
        .o_v_write        (o_v_write),
        .o_restore_status (o_restore_status),
        .o_q_set          (o_q_set)
    );

    // ------------------------------------------------------------------
    // Model of the execute unit
    // ------------------------------------------------------------------

    // Clamp a signed value to a signed range of the given width (1..32).
    function automatic logic [DATA_W-1:0] clamp_signed(input longint v, input int bits,
                                                       inout bit q);
        longint top;
        longint bottom;
        top    = (longint'(1) << (bits - 1)) - 1;
        bottom = -top - 1;
        if (v > top) begin
            q = 1'b1;
            v = top;
        end else if (v < bottom) begin
            q = 1'b1;
            v = bottom;
        end
        return v[DATA_W-1:0];
    endfunction

    // Clamp a signed value to an unsigned range of the given width (0..31).
    function automatic logic [DATA_W-1:0] clamp_unsigned(input longint v, input int bits,
                                                         inout bit q);
        longint top;
        top = (longint'(1) << bits) - 1;
        if (v < 0) begin
            q = 1'b1;
            v = 0;
        end else if (v > top) begin
            q = 1'b1;
            v = top;
        end
        return v[DATA_W-1:0];
    endfunction

    // Sum of the four byte-wise absolute differences, wrapping at 32 bits.
    function automatic logic [DATA_W-1:0] byte_abs_diff_sum(input logic [DATA_W-1:0] a,
                                                            input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] sum;
        logic [7:0]        x;
        logic [7:0]        y;
        sum = '0;
        for (int i = 0; i < 4; i++) begin
            x = a[8*i +: 8];
            y = b[8*i +: 8];
            sum += (x > y) ? DATA_W'(x - y) : DATA_W'(y - x);
        end
        return sum;
    endfunction

    function automatic t_result media_alu_result(input stim_t it);
        t_result           r;
        logic [DATA_W-1:0] t;
        logic [DATA_W:0]   wide;
        longint            lo_half;
        longint            hi_half;
        logic [DATA_W-1:0] lo_res;
        logic [DATA_W-1:0] hi_res;
        int                width;
        bit                q;
        bit                logical;
        r       = '0;
        q       = 1'b0;
        logical = 1'b0;
        case (it.kind)
            OP_AND: begin
                r.result = it.rn & it.op2;
                logical  = 1'b1;
            end
            OP_EOR: begin
                r.result = it.rn ^ it.op2;
                logical  = 1'b1;
            end
            OP_BIC: begin
                r.result = it.rn & ~it.op2;
                logical  = 1'b1;
            end
            OP_ORR: begin
                r.result = it.rn | it.op2;
                logical  = 1'b1;
            end
            OP_CLZ: begin
                // the highest set bit is the last one to write the count
                r.result = DATA_W;
                for (int i = 0; i < DATA_W; i++) begin
                    if (it.op2[i]) r.result = DATA_W - 1 - i;
                end
            end
            OP_CMP: begin
                t = it.rn - it.op2;
                r.flag_n = t[DATA_W-1];
                r.flag_z = (t == '0);
                r.flag_c = (it.rn >= it.op2);
                r.flag_v = (it.rn[DATA_W-1] ^ it.op2[DATA_W-1]) &
                           (it.rn[DATA_W-1] ^ t[DATA_W-1]);
                r.nzc_write = 1'b1;
                r.v_write   = 1'b1;
            end
            OP_CMN: begin
                wide = {1'b0, it.rn} + {1'b0, it.op2};
                t = wide[DATA_W-1:0];
                r.flag_n = t[DATA_W-1];
                r.flag_z = (t == '0);
                r.flag_c = wide[DATA_W];
                r.flag_v = ~(it.rn[DATA_W-1] ^ it.op2[DATA_W-1]) &
                           (it.rn[DATA_W-1] ^ t[DATA_W-1]);
                r.nzc_write = 1'b1;
                r.v_write   = 1'b1;
            end
            OP_TEQ, OP_TST: begin
                t = (it.kind == OP_TEQ) ? (it.rn ^ it.op2) : (it.rn & it.op2);
                r.flag_n    = t[DATA_W-1];
                r.flag_z    = (t == '0);
                r.flag_c    = it.cin;
                r.nzc_write = 1'b1;
            end
            OP_REV:    r.result = {it.op2[7:0], it.op2[15:8], it.op2[23:16], it.op2[31:24]};
            OP_REV16:  r.result = {it.op2[23:16], it.op2[31:24], it.op2[7:0], it.op2[15:8]};
            OP_REVSH:  r.result = {{HALF_W{it.op2[7]}}, it.op2[7:0], it.op2[15:8]};
            OP_PKHBT: begin
                t = it.op2 << it.shift;
                r.result = {t[31:16], it.rn[15:0]};
            end
            OP_PKHTB: begin
                // a zero shift stands for a shift right by 32
                t = (it.shift == '0) ? {DATA_W{it.op2[DATA_W-1]}}
                                     : DATA_W'($signed(it.op2) >>> it.shift);
                r.result = {it.rn[31:16], t[15:0]};
            end
            OP_SSAT, OP_USAT: begin
                if (!it.asr) t = it.op2 << it.shift;
                else if (it.shift == '0) t = {DATA_W{it.op2[DATA_W-1]}};
                else t = DATA_W'($signed(it.op2) >>> it.shift);
                lo_half = longint'($signed(t));
                if (it.kind == OP_SSAT) r.result = clamp_signed(lo_half, int'(it.sat) + 1, q);
                else r.result = clamp_unsigned(lo_half, int'(it.sat), q);
            end
            OP_SSAT16, OP_USAT16: begin
                width   = int'(it.sat[3:0]);
                lo_half = longint'($signed(it.op2[15:0]));
                hi_half = longint'($signed(it.op2[31:16]));
                if (it.kind == OP_SSAT16) begin
                    lo_res = clamp_signed(lo_half, width + 1, q);
                    hi_res = clamp_signed(hi_half, width + 1, q);
                end else begin
                    lo_res = clamp_unsigned(lo_half, width, q);
                    hi_res = clamp_unsigned(hi_half, width, q);
                end
                r.result = {hi_res[15:0], lo_res[15:0]};
            end
            OP_USAD8:  r.result = byte_abs_diff_sum(it.op2, it.rs);
            OP_USADA8: r.result = it.rn + byte_abs_diff_sum(it.op2, it.rs);
            default: ;
        endcase
        r.result_write = (it.kind <= OP_USADA8) && !(it.kind inside {OP_CMP, OP_CMN, OP_TEQ,
                                                                      OP_TST});
        if (logical && it.s_bit) begin
            if (it.pc_dest) begin
                r.restore_status = 1'b1;
            end else begin
                r.flag_n    = r.result[DATA_W-1];
                r.flag_z    = (r.result == '0);
                r.flag_c    = it.cin;
                r.nzc_write = 1'b1;
            end
        end
        r.q_set = q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Favour the values where flags, saturation and sign handling turn over.
    function automatic logic [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return DATA_W'($urandom_range(0, 255));
            5:       return {{HALF_W{w[15]}}, w[15:0]};
            default: return w;
        endcase
    endfunction

    function automatic stim_t random_item();
        stim_t it;
        if ($urandom_range(0, 15) == 0)
            it.kind = KIND_W'($urandom_range(int'(OP_USADA8) + 1, int'(KIND_LAST)));
        else
            it.kind = KIND_W'($urandom_range(0, int'(OP_USADA8)));
        it.rn      = pick_word();
        it.op2     = pick_word();
        it.rs      = pick_word();
        it.cin     = 1'($urandom_range(0, 1));
        it.shift   = ($urandom_range(0, 7) == 0) ? '0 : SHIFT_W'($urandom_range(0, 31));
        it.asr     = 1'($urandom_range(0, 1));
        it.sat     = SAT_W'($urandom_range(0, 31));
        it.s_bit   = 1'($urandom_range(0, 1));
        it.pc_dest = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    function automatic bit in_quiet_window();
        return (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
    endfunction

    // Enter and leave at a falling edge. Idle at random first, then offer the item and
    // hold it until it is taken.
    task automatic send_item(input stim_t it, input t_result want);
        while (!in_quiet_window() && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= it.kind;
        i_first_operand  <= it.rn;
        i_second_operand <= it.op2;
        i_third_operand  <= it.rs;
        i_shifter_carry  <= it.cin;
        i_shift_amount   <= it.shift;
        i_shift_is_asr   <= it.asr;
        i_sat_field      <= it.sat;
        i_set_flags      <= it.s_bit;
        i_dest_is_pc     <= it.pc_dest;
        offered_result   <= want;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin : drive_items
        stim_t it;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_kind           = '0;
        i_first_operand  = '0;
        i_second_operand = '0;
        i_third_operand  = '0;
        i_shifter_carry  = 1'b0;
        i_shift_amount   = '0;
        i_shift_is_asr   = 1'b0;
        i_sat_field      = '0;
        i_set_flags      = 1'b0;
        i_dest_is_pc     = 1'b0;
        offered_result   = '0;
        items_sent       = 0;
        random_sent      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; use the typed-in result where there is one.
        for (int row = 0; row < DIR_ROWS; row++) begin
            it = directed_rows[row].item;
            send_item(it, directed_rows[row].typed ? directed_rows[row].want
                                                    : media_alu_result(it));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == DRAIN_AT) begin
                // Pause until every result is back, then carry on.
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (pending_results.size() != 0);
            end
            it = random_item();
            send_item(it, media_alu_result(it));
            random_sent++;
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d directed and %0d random items over all operations and unused codes;",
                 DIR_ROWS, random_sent);
        $display("%0d results checked, %0d saturating, %0d status restores, %0d mismatches.",
                 results_checked, saturations_seen, restores_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS arm_logic_media_alu_top");
        end else begin
            $display("FAIL arm_logic_media_alu_top");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off that fills the pipe, and a quiet stretch.
    initial begin : drive_out_stall
        int  hold_left;
        bit  hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (in_quiet_window()) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    initial begin
        results_checked  = 0;
        saturations_seen = 0;
        restores_seen    = 0;
        mismatches       = 0;
    end

    // Take results first, then record the item accepted at the same edge behind them.
    always @(posedge i_clk) begin : watch_channels
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, o_result);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result", want.result, o_result);
                    check_field("result_write", DATA_W'(want.result_write), DATA_W'(o_result_write));
                    check_field("flag_n", DATA_W'(want.flag_n), DATA_W'(o_flag_n));
                    check_field("flag_z", DATA_W'(want.flag_z), DATA_W'(o_flag_z));
                    check_field("flag_c", DATA_W'(want.flag_c), DATA_W'(o_flag_c));
                    check_field("flag_v", DATA_W'(want.flag_v), DATA_W'(o_flag_v));
                    check_field("nzc_write", DATA_W'(want.nzc_write), DATA_W'(o_nzc_write));
                    check_field("v_write", DATA_W'(want.v_write), DATA_W'(o_v_write));
                    check_field("restore_status", DATA_W'(want.restore_status),
                                DATA_W'(o_restore_status));
                    check_field("q_set", DATA_W'(want.q_set), DATA_W'(o_q_set));
                    results_checked++;
                    if (want.q_set) saturations_seen++;
                    if (want.restore_status) restores_seen++;
                end
            end
            if (i_in_valid && !o_in_stall) pending_results.push_back(offered_result);
        end
    end

    // Guard against a hung handshake.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due", $time,
                     cycle_count, pending_results.size());
            $display("FAIL arm_logic_media_alu_top");
            $finish;
        end
    end

endmodule
